// ----- rtl/core/all_pairs_shortest_path_unit_macros.svh -----
// Assertion helpers for the shortest path unit.
// Each use expects clk and arst_n in the enclosing module.
`ifndef ALL_PAIRS_SHORTEST_PATH_UNIT_MACROS_SVH
`define ALL_PAIRS_SHORTEST_PATH_UNIT_MACROS_SVH

// Same-cycle implication.
`define APSP_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define APSP_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/apsp_pkg.sv -----
`timescale 1ns / 1ps

package apsp_pkg;

	localparam int OP_W     = 2;
	localparam int NODE_W   = 5;
	localparam int WEIGHT_W = 16;
	localparam int COST_W   = 21;
	localparam int PRED_W   = 5;
	localparam int KIND_W   = 2;
	localparam int CFG_W    = 6;

	localparam logic [CFG_W-1:0] NODE_COUNT_RESET = 6'd32;

	localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
	localparam logic [OP_W-1:0] OP_RUN  = 2'd1;
	localparam logic [OP_W-1:0] OP_READ = 2'd2;

	localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
	localparam logic [KIND_W-1:0] KIND_RUN  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_PAIR = 2'd2;

	typedef struct packed {
		logic                absent;
		logic [WEIGHT_W-1:0] weight;
	} edge_t;

	typedef struct packed {
		logic              inf;
		logic [COST_W-1:0] cost;
	} dist_t;

	typedef struct packed {
		logic              edge_we;
		logic              edge_clear;
		logic              init_issue;
		logic              init_inf;
		logic              init_diag;
		logic [PRED_W-1:0] init_pred;
		logic              ik_capture;
		logic              relax_issue;
		logic              out_load;
		logic              out_run;
		logic              out_read;
		logic              read_in_range;
	} apsp_cmd_t;

	typedef struct packed {
		logic ik_inf;
		logic out_valid;
	} apsp_sts_t;

endpackage

// ----- rtl/core/apsp_ctrl.sv -----
`timescale 1ns / 1ps
`include "all_pairs_shortest_path_unit_macros.svh"

module apsp_ctrl #(
	parameter int MAX_NODES = 32,
	localparam int NW = $clog2(MAX_NODES),
	localparam int CW = $clog2(MAX_NODES * MAX_NODES)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [apsp_pkg::OP_W-1:0]     opcode,
	input  logic [apsp_pkg::NODE_W-1:0]   from_node,
	input  logic [apsp_pkg::NODE_W-1:0]   to_node,
	input  logic                          cfg_we,
	input  logic [apsp_pkg::CFG_W-1:0]    cfg_wdata,
	input  logic                          out_ready,
	input  apsp_pkg::apsp_sts_t           sts,
	output apsp_pkg::apsp_cmd_t           cmd,
	output logic [CW-1:0]                 addr_a,
	output logic [CW-1:0]                 addr_b,
	output logic [CW-1:0]                 edge_waddr
);

	localparam int NCW = (NW + 1 > apsp_pkg::CFG_W) ? NW + 1 : apsp_pkg::CFG_W;
	localparam logic [NW-1:0] LAST_IDX = NW'(MAX_NODES - 1);

	localparam logic [2:0] S_CLEAR = 3'd0;
	localparam logic [2:0] S_IDLE  = 3'd1;
	localparam logic [2:0] S_READ  = 3'd2;
	localparam logic [2:0] S_INIT  = 3'd3;
	localparam logic [2:0] S_IK    = 3'd4;
	localparam logic [2:0] S_IKW   = 3'd5;
	localparam logic [2:0] S_ROW   = 3'd6;
	localparam logic [2:0] S_DONE  = 3'd7;

	logic [2:0]                   state_q, state_d;
	logic [NW-1:0]                i_q, i_d, j_q, j_d, k_q, k_d;
	logic                         rd_range_q, rd_range_d;
	logic [apsp_pkg::CFG_W-1:0]   node_count_q;
	logic [NCW-1:0]               nc_ext, n_act;
	logic [NW-1:0]                n_last;
	logic [NW-1:0]                from_idx, to_idx;
	logic                         in_range, accept, row_end;
	logic                         out_cmd, row_idx_ok, ik_skip, run_accept;

	function automatic logic [CW-1:0] cell_addr(
		input logic [NW-1:0] r,
		input logic [NW-1:0] c
	);
		return CW'(r) * CW'(MAX_NODES) + CW'(c);
	endfunction

	// clamp the vertex count into 1 .. MAX_NODES
	assign nc_ext = NCW'(node_count_q);
	always_comb begin
		if (nc_ext == '0) begin
			n_act = NCW'(1);
		end else if (nc_ext > NCW'(MAX_NODES)) begin
			n_act = NCW'(MAX_NODES);
		end else begin
			n_act = nc_ext;
		end
	end
	assign n_last = NW'(n_act - NCW'(1));

	assign from_idx = NW'(from_node);
	assign to_idx   = NW'(to_node);
	assign in_range = (32'(from_node) < MAX_NODES) && (32'(to_node) < MAX_NODES);
	assign accept   = in_valid && in_ready;

	always_comb begin
		state_d    = state_q;
		i_d        = i_q;
		j_d        = j_q;
		k_d        = k_q;
		rd_range_d = rd_range_q;
		cmd        = '0;
		in_ready   = 1'b0;
		row_end    = 1'b0;
		addr_a     = cell_addr(i_q, j_q);
		addr_b     = cell_addr(k_q, j_q);
		edge_waddr = cell_addr(i_q, j_q);
		case (state_q)
			S_CLEAR: begin
				cmd.edge_we    = 1'b1;
				cmd.edge_clear = 1'b1;
				if (j_q == LAST_IDX) begin
					j_d = '0;
					if (i_q == LAST_IDX) begin
						i_d     = '0;
						state_d = S_IDLE;
					end else begin
						i_d = i_q + 1'b1;
					end
				end else begin
					j_d = j_q + 1'b1;
				end
			end
			S_IDLE: begin
				in_ready   = !sts.out_valid || out_ready;
				addr_b     = cell_addr(from_idx, to_idx);
				edge_waddr = cell_addr(from_idx, to_idx);
				if (accept) begin
					case (opcode)
						apsp_pkg::OP_LOAD: begin
							cmd.edge_we  = in_range;
							cmd.out_load = 1'b1;
						end
						apsp_pkg::OP_RUN: begin
							i_d     = '0;
							j_d     = '0;
							state_d = S_INIT;
						end
						apsp_pkg::OP_READ: begin
							rd_range_d = in_range;
							state_d    = S_READ;
						end
						default: begin
						end
					endcase
				end
			end
			S_READ: begin
				cmd.out_read      = 1'b1;
				cmd.read_in_range = rd_range_q;
				state_d           = S_IDLE;
			end
			S_INIT: begin
				cmd.init_issue = 1'b1;
				cmd.init_inf   = (i_q > n_last) || (j_q > n_last);
				cmd.init_diag  = (i_q == j_q);
				cmd.init_pred  = apsp_pkg::PRED_W'(i_q);
				if (j_q == LAST_IDX) begin
					j_d = '0;
					if (i_q == LAST_IDX) begin
						i_d     = '0;
						k_d     = '0;
						state_d = S_IK;
					end else begin
						i_d = i_q + 1'b1;
					end
				end else begin
					j_d = j_q + 1'b1;
				end
			end
			S_IK: begin
				addr_a  = cell_addr(i_q, k_q);
				state_d = S_IKW;
			end
			S_IKW: begin
				cmd.ik_capture = 1'b1;
				if (sts.ik_inf) begin
					row_end = 1'b1;
				end else begin
					j_d     = '0;
					state_d = S_ROW;
				end
			end
			S_ROW: begin
				cmd.relax_issue = 1'b1;
				if (j_q == n_last) begin
					row_end = 1'b1;
				end else begin
					j_d = j_q + 1'b1;
				end
			end
			S_DONE: begin
				cmd.out_run = 1'b1;
				state_d     = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		// advance to the next row, the next intermediate vertex, or the end of the run
		if (row_end) begin
			if (i_q == n_last) begin
				i_d = '0;
				if (k_q == n_last) begin
					state_d = S_DONE;
				end else begin
					k_d     = k_q + 1'b1;
					state_d = S_IK;
				end
			end else begin
				i_d     = i_q + 1'b1;
				state_d = S_IK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			i_q          <= '0;
			j_q          <= '0;
			k_q          <= '0;
			rd_range_q   <= 1'b0;
			node_count_q <= apsp_pkg::NODE_COUNT_RESET;
		end else begin
			state_q    <= state_d;
			i_q        <= i_d;
			j_q        <= j_d;
			k_q        <= k_d;
			rd_range_q <= rd_range_d;
			if (cfg_we) begin
				node_count_q <= cfg_wdata;
			end
		end
	end

	assign out_cmd    = cmd.out_load || cmd.out_run || cmd.out_read;
	assign row_idx_ok = (i_q <= n_last) && (j_q <= n_last) && (k_q <= n_last);
	assign ik_skip    = (state_q == S_IKW) && sts.ik_inf;
	assign run_accept = accept && (opcode == apsp_pkg::OP_RUN);

	`APSP_ASSERT_IMPLIES(a_no_out_overrun, out_cmd, !sts.out_valid || out_ready, "result overrun")
	`APSP_ASSERT_IMPLIES(a_row_bounds, state_q == S_ROW, row_idx_ok, "index past node count")
	`APSP_ASSERT_NEXT(a_skip_inf_row, ik_skip, state_q != S_ROW, "unreachable row relaxed")
	`APSP_ASSERT_NEXT(a_run_starts, run_accept, state_q == S_INIT, "run did not start init")

endmodule

// ----- rtl/core/apsp_dpath.sv -----
`timescale 1ns / 1ps

module apsp_dpath #(
	parameter int MAX_NODES = 32,
	localparam int CELLS = MAX_NODES * MAX_NODES,
	localparam int CW = $clog2(CELLS)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  apsp_pkg::apsp_cmd_t             cmd,
	output apsp_pkg::apsp_sts_t             sts,
	input  logic [CW-1:0]                   addr_a,
	input  logic [CW-1:0]                   addr_b,
	input  logic [CW-1:0]                   edge_waddr,
	input  logic [apsp_pkg::WEIGHT_W-1:0]   edge_weight,
	input  logic                            edge_absent,
	input  logic                            out_ready,
	output logic                            out_valid,
	output logic [apsp_pkg::KIND_W-1:0]     result_kind,
	output logic [apsp_pkg::COST_W-1:0]     distance,
	output logic                            reachable,
	output logic [apsp_pkg::PRED_W-1:0]     predecessor
);

	localparam apsp_pkg::dist_t DIST_INF  = '{inf: 1'b1, cost: '0};
	localparam apsp_pkg::dist_t DIST_ZERO = '{inf: 1'b0, cost: '0};

	apsp_pkg::edge_t               edge_mem [CELLS];
	apsp_pkg::dist_t               dist_mem [CELLS];
	logic [apsp_pkg::PRED_W-1:0]   pred_mem [CELLS];

	apsp_pkg::edge_t               edge_wdata, edge_rd_s1;
	apsp_pkg::dist_t               dist_a_s1, dist_b_s1, ik_q, dist_wdata;
	logic [apsp_pkg::PRED_W-1:0]   pred_b_s1, pred_wdata;

	logic                          init_s1, relax_s1;
	logic                          init_inf_s1, init_diag_s1;
	logic [apsp_pkg::PRED_W-1:0]   init_pred_s1;
	logic [CW-1:0]                 wr_addr_s1;

	logic [apsp_pkg::COST_W:0]     sum;
	logic                          better, dist_we;

	logic                          out_valid_q;
	logic [apsp_pkg::KIND_W-1:0]   kind_q;
	logic [apsp_pkg::COST_W-1:0]   dist_q;
	logic                          reach_q;
	logic [apsp_pkg::PRED_W-1:0]   pred_q;

	always_comb begin
		if (cmd.edge_clear) begin
			edge_wdata = '{absent: 1'b1, weight: '0};
		end else begin
			edge_wdata = '{absent: edge_absent, weight: edge_weight};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.edge_we) begin
			edge_mem[edge_waddr] <= edge_wdata;
		end
		edge_rd_s1 <= edge_mem[addr_a];
	end

	always_ff @(posedge clk) begin
		if (dist_we) begin
			dist_mem[wr_addr_s1] <= dist_wdata;
			pred_mem[wr_addr_s1] <= pred_wdata;
		end
		dist_a_s1 <= dist_mem[addr_a];
		dist_b_s1 <= dist_mem[addr_b];
		pred_b_s1 <= pred_mem[addr_b];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_s1  <= 1'b0;
			relax_s1 <= 1'b0;
		end else begin
			init_s1  <= cmd.init_issue;
			relax_s1 <= cmd.relax_issue;
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_s1   <= addr_a;
		init_inf_s1  <= cmd.init_inf;
		init_diag_s1 <= cmd.init_diag;
		init_pred_s1 <= cmd.init_pred;
		if (cmd.ik_capture) begin
			ik_q <= dist_a_s1;
		end
	end

	// candidate through the intermediate vertex; drop it on overflow
	assign sum = {1'b0, ik_q.cost} + {1'b0, dist_b_s1.cost};
	assign better = relax_s1 && !dist_b_s1.inf && !sum[apsp_pkg::COST_W] &&
	                (dist_a_s1.inf || (sum[apsp_pkg::COST_W-1:0] < dist_a_s1.cost));
	assign dist_we = init_s1 || better;

	always_comb begin
		if (init_s1) begin
			pred_wdata = init_pred_s1;
			if (init_inf_s1) begin
				dist_wdata = DIST_INF;
			end else if (init_diag_s1) begin
				dist_wdata = DIST_ZERO;
			end else if (edge_rd_s1.absent) begin
				dist_wdata = DIST_INF;
			end else begin
				dist_wdata = '{inf: 1'b0, cost: apsp_pkg::COST_W'(edge_rd_s1.weight)};
			end
		end else begin
			pred_wdata = pred_b_s1;
			dist_wdata = '{inf: 1'b0, cost: sum[apsp_pkg::COST_W-1:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load || cmd.out_run || cmd.out_read) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load || cmd.out_run) begin
			kind_q  <= cmd.out_load ? apsp_pkg::KIND_LOAD : apsp_pkg::KIND_RUN;
			dist_q  <= '0;
			reach_q <= 1'b0;
			pred_q  <= '0;
		end else if (cmd.out_read) begin
			kind_q <= apsp_pkg::KIND_PAIR;
			if (!cmd.read_in_range) begin
				dist_q  <= '0;
				reach_q <= 1'b0;
				pred_q  <= '0;
			end else begin
				dist_q  <= dist_b_s1.inf ? '0 : dist_b_s1.cost;
				reach_q <= !dist_b_s1.inf;
				pred_q  <= pred_b_s1;
			end
		end
	end

	assign sts.ik_inf    = dist_a_s1.inf;
	assign sts.out_valid = out_valid_q;

	assign out_valid   = out_valid_q;
	assign result_kind = kind_q;
	assign distance    = dist_q;
	assign reachable   = reach_q;
	assign predecessor = pred_q;

endmodule

// ----- rtl/core/all_pairs_shortest_path_unit.sv -----
`timescale 1ns / 1ps
// Channel  | Handshake            | Payload
// input    | in_valid / in_ready  | opcode, from_node, to_node, edge_weight, edge_absent
// output   | out_valid / out_ready| result_kind, distance, reachable, predecessor
// config   | cfg_we (no wait)     | cfg_wdata = node_count
//
// Load and opcode 3 complete in S_IDLE; a read first passes S_READ for its memory read.
// A run initializes every cell (S_INIT), then for each intermediate vertex
// and each row reads the row's distance to it (S_IK, S_IKW) and, if reachable, relaxes
// every active column in S_ROW with the single relaxation adder and two-read distance memory.
// After reset a clearing pass marks every edge absent, with in_ready low.
// in_ready is low during a run and while a result waits that is not taken this cycle.

module all_pairs_shortest_path_unit #(
	parameter int MAX_NODES = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [apsp_pkg::OP_W-1:0]       opcode,
	input  logic [apsp_pkg::NODE_W-1:0]     from_node,
	input  logic [apsp_pkg::NODE_W-1:0]     to_node,
	input  logic [apsp_pkg::WEIGHT_W-1:0]   edge_weight,
	input  logic                            edge_absent,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [apsp_pkg::KIND_W-1:0]     result_kind,
	output logic [apsp_pkg::COST_W-1:0]     distance,
	output logic                            reachable,
	output logic [apsp_pkg::PRED_W-1:0]     predecessor,
	input  logic                            cfg_we,
	input  logic [apsp_pkg::CFG_W-1:0]      cfg_wdata
);

	localparam int CW = $clog2(MAX_NODES * MAX_NODES);

	apsp_pkg::apsp_cmd_t cmd;
	apsp_pkg::apsp_sts_t sts;
	logic [CW-1:0]       addr_a, addr_b, edge_waddr;

	// sequencer: clearing pass, transfer decode, init sweep and k/i/j relaxation loops
	apsp_ctrl #(
		.MAX_NODES (MAX_NODES)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.opcode     (opcode),
		.from_node  (from_node),
		.to_node    (to_node),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.out_ready  (out_ready),
		.sts        (sts),
		.cmd        (cmd),
		.addr_a     (addr_a),
		.addr_b     (addr_b),
		.edge_waddr (edge_waddr)
	);

	// stores, relaxation adder and compare, output register
	apsp_dpath #(
		.MAX_NODES (MAX_NODES)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.addr_a      (addr_a),
		.addr_b      (addr_b),
		.edge_waddr  (edge_waddr),
		.edge_weight (edge_weight),
		.edge_absent (edge_absent),
		.out_ready   (out_ready),
		.out_valid   (out_valid),
		.result_kind (result_kind),
		.distance    (distance),
		.reachable   (reachable),
		.predecessor (predecessor)
	);

endmodule
